>>> hdl/fsb_pkg.sv
// Shared types and constants for the symbol binning block.
// No dependencies; every other file imports this package.
package fsb_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int SEG_BITS    = 4;
    localparam int SLOT_BITS   = 10;
    localparam int BP_BITS     = 8;
    localparam int ALPHA_BITS  = 9;
    localparam int COUNT_BITS  = 11;
    localparam int SEGS_BITS   = 5;
    localparam int NUM_BITS    = VALUE_BITS + BP_BITS;
    localparam int CLR_BITS    = SEG_BITS + BP_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ALPHA_BITS-1:0] ALPHA_MIN = ALPHA_BITS'(2);
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = ALPHA_BITS'(256);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(1024);
    localparam logic [SEGS_BITS-1:0]  SEGS_MAX  = SEGS_BITS'(16);
    localparam logic [VALUE_BITS-1:0] VALUE_LARGEST = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_QUANT   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ALPHABET = 2'd0,
        REG_MODE     = 2'd1,
        REG_COUNT    = 2'd2,
        REG_SEGS     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [SEG_BITS-1:0]    seg;
        logic [SLOT_BITS-1:0]   slot;
        logic [VALUE_BITS-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]  alpha;
        logic                   depth_mode;
        logic [COUNT_BITS-1:0]  count;
        logic [SEGS_BITS-1:0]   segs;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_RD,
        ST_Q_CMP,
        ST_C_SEG,
        ST_S_OUTER,
        ST_S_KEY,
        ST_S_RD,
        ST_S_CMP,
        ST_C_LO,
        ST_C_HI0,
        ST_C_HI,
        ST_C_J,
        ST_C_DIV,
        ST_C_RDQ
    } state_t;

endpackage

>>> hdl/fsb_front.sv
// Front end: accepts command beats, drops unknown commands, queues the rest.
// Depends on fsb_pkg.
module fsb_front
    import fsb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   in_item,
    input  logic    clearing,
    input  logic    pop,
    output logic    busy,
    output item_t   head,
    output q_stat_t stat
);

    item_t      q_mem [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept, push;

    assign busy   = (count_reg == 2'(QUEUE_DEPTH)) || clearing;
    assign accept = start && !busy;
    assign push   = accept && (in_item.cmd != CMD_NONE);
    assign head   = q_mem[rd_ptr_reg];

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hdl/fsb_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on fsb_pkg.
module fsb_divider
    import fsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [NUM_BITS-1:0]   num,
    input  logic [ALPHA_BITS-1:0] den,
    output logic                  done,
    output logic [NUM_BITS-1:0]   quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]   nsh_reg, nsh_next;
    logic [ALPHA_BITS-1:0] rem_reg, rem_next;
    logic [ALPHA_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [ALPHA_BITS:0]   trial;

    assign done  = done_reg;
    assign quot  = nsh_reg;
    assign trial = {rem_reg, nsh_reg[NUM_BITS-1]};

    always_comb
    begin
        nsh_next  = nsh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (go)
        begin
            nsh_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_BITS'(NUM_BITS);
        end
        else if (cnt_reg != '0)
        begin
            // shift one numerator bit into the remainder, subtract if it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = ALPHA_BITS'(trial - {1'b0, den_reg});
                nsh_next = {nsh_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ALPHA_BITS-1:0];
                nsh_next = {nsh_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsh_reg <= nsh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

>>> hdl/fsb_back.sv
// Back end: sample and breakpoint memories, sort, breakpoint and quantize sequencer.
// Depends on fsb_pkg and fsb_divider.
module fsb_back
    import fsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  item_t                 head,
    input  q_stat_t               stat,
    output logic                  pop,
    output logic                  clearing,
    output logic                  result_valid,
    output logic [BP_BITS-1:0]    symbol,
    output logic                  compute_done
);

    localparam int SADDR_BITS = SEG_BITS + SLOT_BITS;

    logic [VALUE_BITS-1:0] sample_mem [2**SADDR_BITS];
    logic [VALUE_BITS-1:0] bp_mem [2**CLR_BITS];

    state_t state_reg, state_next;

    logic [SEGS_BITS-1:0]  s_reg, s_next;
    logic [COUNT_BITS-1:0] i_reg, i_next;
    logic [COUNT_BITS-1:0] k_reg, k_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] lo_reg, lo_next;
    logic [VALUE_BITS-1:0] span_reg, span_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [BP_BITS-1:0]    j_reg, j_next;
    logic [BP_BITS-1:0]    c_reg, c_next;
    logic [CLR_BITS-1:0]   clr_reg, clr_next;
    logic [SEG_BITS-1:0]   seg_reg, seg_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  res_reg, res_next;
    logic [BP_BITS-1:0]    sym_reg, sym_next;
    logic                  done_reg, done_next;

    logic                  smem_we;
    logic [SADDR_BITS-1:0] smem_waddr, smem_raddr;
    logic [VALUE_BITS-1:0] smem_wdata, smem_rdata_reg;
    logic                  bmem_we;
    logic [CLR_BITS-1:0]   bmem_waddr, bmem_raddr;
    logic [VALUE_BITS-1:0] bmem_wdata, bmem_rdata_reg;

    logic                  div_go, div_done;
    logic [NUM_BITS-1:0]   div_quot;

    logic [ALPHA_BITS-1:0] j_plus1, c_plus1;
    logic [COUNT_BITS-1:0] k_minus1, n_minus1;

    assign j_plus1  = {1'b0, j_reg} + 1'b1;
    assign c_plus1  = {1'b0, c_reg} + 1'b1;
    assign k_minus1 = k_reg - 1'b1;
    assign n_minus1 = cfg.count - 1'b1;

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = res_reg;
    assign symbol       = sym_reg;
    assign compute_done = done_reg;
    assign pop          = (state_reg == ST_IDLE) && !stat.empty;

    fsb_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (num_next),
        .den  (cfg.alpha),
        .done (div_done),
        .quot (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    if (head.cmd == CMD_QUANT)        state_next = ST_Q_RD;
                    else if (head.cmd == CMD_COMPUTE) state_next = ST_C_SEG;
                end
            end
            ST_Q_RD:    state_next = (c_plus1 >= cfg.alpha) ? ST_IDLE : ST_Q_CMP;
            ST_Q_CMP:   state_next = ($signed(val_reg) < $signed(bmem_rdata_reg))
                                     ? ST_IDLE : ST_Q_RD;
            ST_C_SEG:   state_next = (s_reg >= cfg.segs) ? ST_IDLE : ST_S_OUTER;
            ST_S_OUTER: state_next = (i_reg >= cfg.count) ? ST_C_LO : ST_S_KEY;
            ST_S_KEY:   state_next = ST_S_RD;
            ST_S_RD:    state_next = (k_reg == '0) ? ST_S_OUTER : ST_S_CMP;
            ST_S_CMP:   state_next = ($signed(smem_rdata_reg) > $signed(key_reg))
                                     ? ST_S_RD : ST_S_OUTER;
            ST_C_LO:    state_next = ST_C_HI0;
            ST_C_HI0:   state_next = ST_C_HI;
            ST_C_HI:    state_next = ST_C_J;
            ST_C_J:     state_next = (j_plus1 >= cfg.alpha) ? ST_C_SEG : ST_C_DIV;
            ST_C_DIV:
            begin
                if (div_done) state_next = cfg.depth_mode ? ST_C_RDQ : ST_C_J;
            end
            ST_C_RDQ:   state_next = ST_C_J;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_next    = s_reg;
        i_next    = i_reg;
        k_next    = k_reg;
        key_next  = key_reg;
        lo_next   = lo_reg;
        span_next = span_reg;
        num_next  = num_reg;
        j_next    = j_reg;
        c_next    = c_reg;
        clr_next  = clr_reg;
        seg_next  = seg_reg;
        val_next  = val_reg;
        res_next  = 1'b0;
        sym_next  = sym_reg;
        done_next = done_reg;
        smem_we    = 1'b0;
        smem_waddr = {s_reg[SEG_BITS-1:0], k_reg[SLOT_BITS-1:0]};
        smem_wdata = key_reg;
        smem_raddr = {s_reg[SEG_BITS-1:0], i_reg[SLOT_BITS-1:0]};
        bmem_we    = 1'b0;
        bmem_waddr = {s_reg[SEG_BITS-1:0], j_reg};
        bmem_wdata = lo_reg + div_quot[VALUE_BITS-1:0];
        bmem_raddr = {seg_reg, c_reg};
        div_go     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                bmem_we    = 1'b1;
                bmem_waddr = clr_reg;
                bmem_wdata = VALUE_LARGEST;
                clr_next   = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    seg_next = head.seg;
                    val_next = head.value;
                    c_next   = '0;
                    s_next   = '0;
                    if (head.cmd == CMD_LOAD)
                    begin
                        smem_we    = 1'b1;
                        smem_waddr = {head.seg, head.slot};
                        smem_wdata = head.value;
                    end
                end
            end
            ST_Q_RD:
            begin
                if (c_plus1 >= cfg.alpha)
                begin
                    res_next  = 1'b1;
                    sym_next  = c_reg;
                    done_next = 1'b0;
                end
            end
            ST_Q_CMP:
            begin
                if ($signed(val_reg) < $signed(bmem_rdata_reg))
                begin
                    res_next  = 1'b1;
                    sym_next  = c_reg;
                    done_next = 1'b0;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_C_SEG:
            begin
                i_next = COUNT_BITS'(1);
                if (s_reg >= cfg.segs)
                begin
                    res_next  = 1'b1;
                    sym_next  = '0;
                    done_next = 1'b1;
                end
            end
            ST_S_KEY:
            begin
                key_next = smem_rdata_reg;
                k_next   = i_reg;
            end
            ST_S_RD:
            begin
                smem_raddr = {s_reg[SEG_BITS-1:0], k_minus1[SLOT_BITS-1:0]};
                if (k_reg == '0)
                begin
                    smem_we = 1'b1;
                    i_next  = i_reg + 1'b1;
                end
            end
            ST_S_CMP:
            begin
                // shift the larger neighbor up, or drop the key into its slot
                smem_we = 1'b1;
                if ($signed(smem_rdata_reg) > $signed(key_reg))
                begin
                    smem_wdata = smem_rdata_reg;
                    k_next     = k_minus1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_C_LO:
            begin
                smem_raddr = {s_reg[SEG_BITS-1:0], {SLOT_BITS{1'b0}}};
            end
            ST_C_HI0:
            begin
                lo_next    = smem_rdata_reg;
                smem_raddr = {s_reg[SEG_BITS-1:0], n_minus1[SLOT_BITS-1:0]};
            end
            ST_C_HI:
            begin
                span_next = smem_rdata_reg - lo_reg;
                num_next  = '0;
                j_next    = '0;
            end
            ST_C_J:
            begin
                if (j_plus1 >= cfg.alpha)
                begin
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    num_next = num_reg + (cfg.depth_mode
                               ? NUM_BITS'(cfg.count) : NUM_BITS'(span_reg));
                    div_go   = 1'b1;
                end
            end
            ST_C_DIV:
            begin
                smem_raddr = {s_reg[SEG_BITS-1:0], div_quot[SLOT_BITS-1:0]};
                if (div_done && !cfg.depth_mode)
                begin
                    bmem_we = 1'b1;
                    j_next  = j_reg + 1'b1;
                end
            end
            ST_C_RDQ:
            begin
                bmem_we    = 1'b1;
                bmem_wdata = smem_rdata_reg;
                j_next     = j_reg + 1'b1;
            end
            default:
            begin
                res_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        key_reg  <= key_next;
        lo_reg   <= lo_next;
        span_reg <= span_next;
        num_reg  <= num_next;
        j_reg    <= j_next;
        c_reg    <= c_next;
        seg_reg  <= seg_next;
        val_reg  <= val_next;
        sym_reg  <= sym_next;
        done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            sample_mem[smem_waddr] <= smem_wdata;
        end
        smem_rdata_reg <= sample_mem[smem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bmem_we)
        begin
            bp_mem[bmem_waddr] <= bmem_wdata;
        end
        bmem_rdata_reg <= bp_mem[bmem_raddr];
    end

endmodule

>>> hdl/fourier_symbol_binning.sv
// Top level of the symbol binning block: configuration registers and wiring.
// Depends on fsb_pkg, fsb_front, fsb_back (and fsb_divider below it).
//
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and busy
//   low. command LOAD writes value into slot sample_slot of column segment and
//   gives no result; COMPUTE sorts every active column and rebuilds its
//   breakpoints; QUANT maps value to a symbol for its segment. Command 3 is
//   taken and dropped.
//   Result channel: result_valid strobes for one cycle with symbol and
//   compute_done. The receiver cannot stall; results leave in command order.
//   Config: write cfg_wdata to register cfg_addr at an edge with cfg_we high,
//   only while no command is pending.
//   Flow: a two-beat queue sits in front of the sequencer, so busy rises only
//   when it is full or during the reset sweep. A load is written from the idle
//   state. A quantize scans the breakpoint memory linearly through one read
//   port, one breakpoint at a time. A compute runs an insertion sort in the
//   sample memory for each segment, then runs the serial divider once per
//   breakpoint.
//   Reset: breakpoint memory is swept to the largest value with busy high;
//   registers return to their reset values at once.
module fourier_symbol_binning
    import fsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [SEG_BITS-1:0]   segment,
    input  logic [SLOT_BITS-1:0]  sample_slot,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    output logic                  result_valid,
    output logic [BP_BITS-1:0]    symbol,
    output logic                  compute_done
);

    logic [ALPHA_BITS-1:0] alpha_reg;
    logic                  mode_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SEGS_BITS-1:0]  segs_reg;

    cfg_t    cfg;
    item_t   in_item;
    item_t   head;
    q_stat_t stat;
    logic    pop;
    logic    clearing;

    // hold register writes; saturate out-of-range values on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_BITS'(8);
            mode_reg  <= 1'b1;
            count_reg <= COUNT_MAX;
            segs_reg  <= SEGS_MAX;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_ALPHABET: alpha_reg <= cfg_wdata[ALPHA_BITS-1:0];
                REG_MODE:     mode_reg  <= cfg_wdata[0];
                REG_COUNT:    count_reg <= cfg_wdata;
                REG_SEGS:     segs_reg  <= cfg_wdata[SEGS_BITS-1:0];
                default:      mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.alpha      = (alpha_reg < ALPHA_MIN) ? ALPHA_MIN
                       : ((alpha_reg > ALPHA_MAX) ? ALPHA_MAX : alpha_reg);
        cfg.depth_mode = mode_reg;
        cfg.count      = (count_reg == '0) ? COUNT_BITS'(1)
                       : ((count_reg > COUNT_MAX) ? COUNT_MAX : count_reg);
        cfg.segs       = (segs_reg == '0) ? SEGS_BITS'(1)
                       : ((segs_reg > SEGS_MAX) ? SEGS_MAX : segs_reg);
    end

    assign in_item.cmd   = cmd_t'(command);
    assign in_item.seg   = segment;
    assign in_item.slot  = sample_slot;
    assign in_item.value = value;

    fsb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .clearing(clearing),
        .pop     (pop),
        .busy    (busy),
        .head    (head),
        .stat    (stat)
    );

    fsb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .clearing    (clearing),
        .result_valid(result_valid),
        .symbol      (symbol),
        .compute_done(compute_done)
    );

    // the sequencer returns to idle after every result, so strobes never come back to back
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back result strobes");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= 2'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_compute_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && compute_done) |-> (symbol == '0))
        else $error("compute result carries a symbol");

    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop)
        else $error("command popped during clearing sweep");

endmodule

>>> tb/fourier_symbol_binning_test.sv
// Self-checking testbench for fourier_symbol_binning: a queue-fed command driver,
// a result monitor and a scoreboard fed by an in-bench model of the binning.
// Depends on fsb_pkg and the block's RTL.
`timescale 1ns / 1ps

module fourier_symbol_binning_test;
    import fsb_pkg::*;

    localparam int NSEG   = 16;
    localparam int NSLOT  = 1024;
    localparam int NBP    = 255;
    localparam int SETTLE = 16;

    // One entry of the stimulus queue: either a command beat or a register write.
    typedef struct {
        bit                    is_cfg;
        cmd_t                  cmd;
        logic [SEG_BITS-1:0]   seg;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] val;
        reg_idx_t              addr;
        logic [COUNT_BITS-1:0] data;
    } beat_t;

    typedef struct {
        logic [BP_BITS-1:0] symbol;
        logic               done;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            command = CMD_NONE;
    logic [SEG_BITS-1:0]   segment = '0;
    logic [SLOT_BITS-1:0]  sample_slot = '0;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_addr = REG_ALPHABET;
    logic [COUNT_BITS-1:0] cfg_wdata = '0;
    logic                  result_valid;
    logic [BP_BITS-1:0]    symbol;
    logic                  compute_done;

    fourier_symbol_binning i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .segment      (segment),
        .sample_slot  (sample_slot),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .symbol       (symbol),
        .compute_done (compute_done)
    );

    beat_t    pending_q[$];
    outcome_t expected_q[$];
    int       mismatch_count = 0;

    // Shadow state of the block: registers, sample columns and breakpoints.
    logic [ALPHA_BITS-1:0]        alpha_r = 9'd8;
    logic                         depth_r = 1'b1;
    logic [COUNT_BITS-1:0]        count_r = 11'd1024;
    logic [SEGS_BITS-1:0]         segs_r  = 5'd16;
    logic signed [VALUE_BITS-1:0] sample_mem [NSEG][NSLOT];
    logic signed [VALUE_BITS-1:0] bp_mem [NSEG][NBP];

    // Stimulus-side pool of loaded values, reused to hit breakpoints exactly.
    logic [VALUE_BITS-1:0] value_pool[$];

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        for (int s = 0; s < NSEG; s++)
            for (int j = 0; j < NBP; j++)
                bp_mem[s][j] = VALUE_LARGEST;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic apply_register(reg_idx_t idx, logic [COUNT_BITS-1:0] data);
        case (idx)
            REG_ALPHABET: alpha_r = data[ALPHA_BITS-1:0];
            REG_MODE:     depth_r = data[0];
            REG_COUNT:    count_r = data;
            REG_SEGS:     segs_r  = data[SEGS_BITS-1:0];
            default: ;
        endcase
    endtask

    // Sort every active column and rebuild its breakpoints.
    task automatic rebuild_breakpoints();
        int a, n, segs, k;
        logic signed [VALUE_BITS-1:0] key;
        logic signed [63:0] lo, span, q, r, off;
        a    = clamp_int(int'(alpha_r), 2, 256);
        n    = clamp_int(int'(count_r), 1, NSLOT);
        segs = clamp_int(int'(segs_r), 1, NSEG);
        for (int s = 0; s < segs; s++) begin
            for (int i = 1; i < n; i++) begin
                key = sample_mem[s][i];
                k = i;
                while (k > 0 && sample_mem[s][k-1] > key) begin
                    sample_mem[s][k] = sample_mem[s][k-1];
                    k--;
                end
                sample_mem[s][k] = key;
            end
            if (depth_r) begin
                for (int j = 0; j + 1 < a; j++)
                    bp_mem[s][j] = sample_mem[s][((j + 1) * n) / a];
            end else begin
                lo   = 64'(sample_mem[s][0]);
                span = 64'(sample_mem[s][n-1]) - lo;
                q    = span / a;
                r    = span % a;
                for (int j = 0; j + 1 < a; j++) begin
                    off = q * (j + 1) + (r * (j + 1)) / a;
                    bp_mem[s][j] = VALUE_BITS'(lo + off);
                end
            end
        end
    endtask

    // Work out what one accepted beat does and queue its result, if any.
    task automatic predict_beat(beat_t b);
        outcome_t o;
        int a, c;
        o.symbol = '0;
        o.done   = 1'b0;
        case (b.cmd)
            CMD_LOAD: sample_mem[b.seg][b.slot] = b.val;
            CMD_COMPUTE:
            begin
                rebuild_breakpoints();
                o.done = 1'b1;
                expected_q.push_back(o);
            end
            CMD_QUANT:
            begin
                a = clamp_int(int'(alpha_r), 2, 256);
                c = 0;
                while (c + 1 < a && !($signed(b.val) < bp_mem[b.seg][c]))
                    c++;
                o.symbol = BP_BITS'(c);
                expected_q.push_back(o);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, int got, int want);
        $display("%t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: bursts of beats with random gaps; register writes wait for quiet.
    int burst_left = 1;
    int gap_left = 0;
    int quiet = 0;

    always @(posedge clk) begin
        logic  nxt_start;
        logic  nxt_we;
        beat_t hd;
        if (rst_n) begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            if (start && !busy) begin
                predict_beat(pending_q[0]);
                pending_q.pop_front();
                quiet = 0;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                quiet++;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                hd = pending_q[0];
                if (hd.is_cfg) begin
                    // Hold the write until every result is in and loads have drained.
                    if (expected_q.size() == 0 && quiet >= SETTLE) begin
                        nxt_we = 1'b1;
                        cfg_addr <= hd.addr;
                        cfg_wdata <= hd.data;
                        apply_register(hd.addr, hd.data);
                        pending_q.pop_front();
                        quiet = 0;
                    end
                end else begin
                    nxt_start = 1'b1;
                    command <= hd.cmd;
                    segment <= hd.seg;
                    sample_slot <= hd.slot;
                    value <= hd.val;
                end
            end
            start <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // Monitor: every strobe must match the oldest expectation.
    always @(posedge clk) begin
        outcome_t want;
        if (rst_n && result_valid) begin
            if (expected_q.size() == 0) begin
                report("unexpected result symbol", int'(symbol), -1);
            end else begin
                want = expected_q.pop_front();
                if (symbol !== want.symbol)
                    report("symbol", int'(symbol), int'(want.symbol));
                if (compute_done !== want.done)
                    report("compute_done", int'(compute_done), int'(want.done));
            end
        end
    end

    task automatic add_beat(cmd_t c, int seg, int slot, logic [VALUE_BITS-1:0] v);
        beat_t b;
        b.is_cfg = 1'b0;
        b.cmd = c;
        b.seg = SEG_BITS'(seg);
        b.slot = SLOT_BITS'(slot);
        b.val = v;
        b.addr = REG_ALPHABET;
        b.data = '0;
        pending_q.push_back(b);
        if (c == CMD_LOAD)
            value_pool.push_back(v);
    endtask

    task automatic add_write(reg_idx_t idx, int data);
        beat_t b;
        b.is_cfg = 1'b1;
        b.cmd = CMD_NONE;
        b.seg = '0;
        b.slot = '0;
        b.val = '0;
        b.addr = idx;
        b.data = COUNT_BITS'(data);
        pending_q.push_back(b);
    endtask

    // Mix of full-range, extreme, repeated and small values to force ties.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return value_pool.size() ? value_pool[$urandom_range(0, value_pool.size()-1)]
                                           : $urandom;
            4: return VALUE_BITS'($signed($urandom_range(0, 6)) - 3) << 16;
            default: return $urandom;
        endcase
    endfunction

    // One configuration phase: write all registers, fill the active columns,
    // compute, probe with directed quantizes, then a random mix, a final compute and a quantize.
    task automatic run_phase(int alpha_w, int mode_w, int count_w, int segs_w,
                             int n_rand, bit sorted_fill);
        int n, segs, pick, seg;
        logic [VALUE_BITS-1:0] v;
        add_write(REG_ALPHABET, alpha_w);
        add_write(REG_MODE, mode_w);
        add_write(REG_COUNT, count_w);
        add_write(REG_SEGS, segs_w);
        n    = clamp_int(count_w & 11'h7FF, 1, NSLOT);
        segs = clamp_int(segs_w & 5'h1F, 1, NSEG);
        for (int s = 0; s < segs; s++)
            for (int i = 0; i < n; i++) begin
                v = sorted_fill ? 32'h8000_0000 + 32'(i) * 32'h0040_0000 : pick_value();
                add_beat(CMD_LOAD, s, i, v);
            end
        add_beat(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 1023), $urandom);
        add_beat(CMD_QUANT, 0, 0, 32'h8000_0000);
        add_beat(CMD_QUANT, segs - 1, 1023, 32'h7FFF_FFFF);
        add_beat(CMD_QUANT, 15, 0, value_pool[value_pool.size()-1]);
        add_beat(CMD_NONE, 15, 1023, 32'hFFFF_FFFF);
        for (int i = 0; i < n_rand; i++) begin
            pick = $urandom_range(0, 99);
            seg  = $urandom_range(0, 15);
            if (pick < 68)
                add_beat(CMD_QUANT, seg, $urandom_range(0, 1023), pick_value());
            else if (pick < 92) begin
                // Keep a large sorted column sorted so its next compute stays short.
                if (sorted_fill && seg == 0)
                    seg = 1;
                add_beat(CMD_LOAD, seg, $urandom_range(0, 1023), pick_value());
            end else if (pick < 96)
                add_beat(CMD_COMPUTE, seg, $urandom_range(0, 1023), $urandom);
            else
                add_beat(CMD_NONE, seg, $urandom_range(0, 1023), $urandom);
        end
        add_beat(CMD_COMPUTE, 0, 0, '0);
        add_beat(CMD_QUANT, $urandom_range(0, 15), 0, pick_value());
    endtask

    initial begin
        // At reset no column is filled: quantize against the reset breakpoints only.
        add_beat(CMD_QUANT, 0, 0, 32'h7FFF_FFFF);
        add_beat(CMD_QUANT, 15, 1023, 32'h7FFF_FFFE);
        add_beat(CMD_QUANT, 7, 512, 32'h8000_0000);
        add_beat(CMD_LOAD, 15, 1023, 32'h7FFF_FFFF);
        add_beat(CMD_NONE, 3, 5, 32'h1234_5678);

        run_phase(8, 1, 6, 16, 60, 1'b0);
        run_phase(256, 0, 4, 2, 60, 1'b0);
        run_phase(2, 1, 0, 1, 50, 1'b0);
        run_phase(0, 0, 12, 4, 60, 1'b0);
        // Out-of-range writes saturate; the column is loaded in order.
        run_phase(300, 1, 64, 0, 50, 1'b1);
        run_phase(5, 0, 6, 16, 40, 1'b0);
        run_phase(511, 1, 3, 31, 40, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit, far beyond the slowest legal run including the reset sweep.
    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
